>>> rtl/core/nte_pkg.sv
// Shared types, codes and defaults for the neighbor table with expiry.
package nte_pkg;

   // Defaults
   localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
   localparam logic [31:0] TIMEOUT_RESET       = 32'd10000;

   // Command codes
   localparam logic CMD_OBSERVE = 1'b0;
   localparam logic CMD_SWEEP   = 1'b1;

   // Address type codes
   localparam logic ADDR_IPV4 = 1'b0;
   localparam logic ADDR_IPV6 = 1'b1;

   // Result status codes
   localparam logic [2:0] STATUS_ADDED      = 3'd0;
   localparam logic [2:0] STATUS_REFRESHED  = 3'd1;
   localparam logic [2:0] STATUS_KNOWN      = 3'd2;
   localparam logic [2:0] STATUS_FULL       = 3'd3;
   localparam logic [2:0] STATUS_SWEEP_DONE = 3'd4;

   // Input transaction payload
   typedef struct packed {
      logic        cmd;
      logic        addr_type;
      logic [15:0] port;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic        is_self;
      logic [47:0] time_ms;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [2:0] status;
      logic [4:0] removed_count;
      logic [4:0] neighbor_count;
   } rsp_type;

   // One stored neighbor
   typedef struct packed {
      logic        addr_type;
      logic [15:0] port;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [47:0] time_ms;
   } entry_type;

   // Row-wide step control from the sequencer
   typedef struct packed {
      logic shift;   // cells below the write position take their upper neighbor
      logic wen;     // cell at the write position takes the write data
   } chain_ctl_type;

   // Per-cell load selects
   typedef struct packed {
      logic load_next;
      logic load_wdata;
   } cell_ctl_type;

endpackage

>>> rtl/core/neighbor_table_with_expiry.sv
// Top level: neighbor table sequencer, timeout register and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------
//   req     | in        | req_valid / req_ready  | req_payload (req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_payload (rsp_type)
//   csr     | in        | csr_valid / csr_ready  | csr_data (timeout, ms)
//
// For each item the sequencer walks the N entries held: the row of cells rotates
// one entry per cycle past the head comparator, the finish state appends and loads
// the result, which is then offered, and the idle state takes the next transaction.
// A waiting result stalls the sequencer only when the next result is ready to be written.
// Reset clears the entry count and loads the timeout (10000 ms); cells need no reset.
module neighbor_table_with_expiry #(
   parameter int unsigned TABLE_DEPTH = nte_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nte_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nte_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);
   localparam logic [COUNT_W-1:0] ONE_C   = COUNT_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   nte_pkg::req_type   req_ff, req_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic [COUNT_W-1:0] removed_ff, removed_in;
   logic               match_ff, match_in;
   logic [31:0]        timeout_ff, timeout_in;
   logic               rsp_valid_ff, rsp_valid_in;
   nte_pkg::rsp_type   rsp_ff, rsp_in;

   nte_pkg::chain_ctl_type chain_ctl;
   logic [COUNT_W-1:0]     wpos;
   nte_pkg::entry_type     wdata;
   nte_pkg::entry_type     head;
   nte_pkg::entry_type     new_entry;

   logic               hit;
   logic [48:0]        expire_at;
   logic               expired;
   logic               finish_go;
   logic [COUNT_W+4:0] removed_wide;
   logic [COUNT_W+4:0] count_wide;

   nte_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_W     (COUNT_W)
   ) u_chain (
      .clock (clock),
      .ctl   (chain_ctl),
      .wpos  (wpos),
      .wdata (wdata),
      .head  (head)
   );

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Timeout register
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   // Entry built from the held request
   always_comb begin
      new_entry.addr_type = req_ff.addr_type;
      new_entry.port      = req_ff.port;
      new_entry.addr_high = req_ff.address_high;
      new_entry.addr_low  = req_ff.address_low;
      new_entry.time_ms   = req_ff.time_ms;
   end

   // Head comparator: match for observe, expiry for sweep
   assign hit = (req_ff.cmd == nte_pkg::CMD_OBSERVE) &&
                (head.addr_type == req_ff.addr_type) &&
                (head.port == req_ff.port) &&
                (head.addr_high == req_ff.address_high) &&
                (head.addr_low == req_ff.address_low);
   assign expire_at = {1'b0, head.time_ms} + {17'd0, timeout_ff};
   assign expired   = expire_at <= {1'b0, req_ff.time_ms};

   assign finish_go = !rsp_valid_ff || rsp_ready;

   // Report widths to five bits
   assign removed_wide = {5'd0, removed_ff};
   assign count_wide   = {5'd0, count_in};

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      removed_in      = removed_ff;
      match_in        = match_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      chain_ctl.shift = 1'b0;
      chain_ctl.wen   = 1'b0;
      wpos            = count_ff;
      wdata           = new_entry;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // IPv4 keeps only the low 32 address bits
               req_in = req_payload;
               if (req_payload.addr_type == nte_pkg::ADDR_IPV4) begin
                  req_in.address_high = 64'd0;
                  req_in.address_low  = {32'd0, req_payload.address_low[31:0]};
               end
               remain_in  = count_ff;
               removed_in = '0;
               match_in   = 1'b0;
               state_in   = (count_ff == '0) ? ST_FINISH : ST_WALK;
            end
         end
         ST_WALK: begin
            // Head leaves; it is dropped or rewritten at the live tail
            chain_ctl.shift = 1'b1;
            wpos            = count_ff - ONE_C;
            if ((req_ff.cmd == nte_pkg::CMD_SWEEP) && expired) begin
               count_in   = count_ff - ONE_C;
               removed_in = removed_ff + ONE_C;
            end else begin
               chain_ctl.wen = 1'b1;
               wdata         = head;
               if (hit && req_ff.is_self) begin
                  wdata.time_ms = req_ff.time_ms;
               end
               match_in = match_ff || hit;
            end
            remain_in = remain_ff - ONE_C;
            if (remain_ff == ONE_C) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_in.removed_count = 5'd0;
               if (req_ff.cmd == nte_pkg::CMD_SWEEP) begin
                  rsp_in.status        = nte_pkg::STATUS_SWEEP_DONE;
                  rsp_in.removed_count = removed_wide[4:0];
               end else if (match_ff) begin
                  rsp_in.status = req_ff.is_self ? nte_pkg::STATUS_REFRESHED
                                                 : nte_pkg::STATUS_KNOWN;
               end else if (count_ff < DEPTH_C) begin
                  // Append at the first free cell
                  chain_ctl.wen = 1'b1;
                  wpos          = count_ff;
                  wdata         = new_entry;
                  count_in      = count_ff + ONE_C;
                  rsp_in.status = nte_pkg::STATUS_ADDED;
               end else begin
                  rsp_in.status = nte_pkg::STATUS_FULL;
               end
               rsp_in.neighbor_count = count_wide[4:0];
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= nte_pkg::TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         timeout_ff   <= timeout_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      remain_ff  <= remain_in;
      removed_ff <= removed_in;
      match_ff   <= match_in;
      rsp_ff     <= rsp_in;
   end

endmodule

>>> rtl/core/nte_cell.sv
// One table cell: holds a single neighbor entry and passes it down the row.
module nte_cell (
   input  logic                  clock,
   input  nte_pkg::cell_ctl_type ctl,
   input  nte_pkg::entry_type    next_i,
   input  nte_pkg::entry_type    wdata_i,
   output nte_pkg::entry_type    data_o
);

   nte_pkg::entry_type data_ff;
   nte_pkg::entry_type data_in;

   // Write data wins over the neighbor shift
   always_comb begin
      data_in = data_ff;
      if (ctl.load_wdata) begin
         data_in = wdata_i;
      end else if (ctl.load_next) begin
         data_in = next_i;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_o = data_ff;

endmodule

>>> rtl/core/nte_chain.sv
// Row of table cells; cell 0 is the head that the sequencer inspects.
module nte_chain #(
   parameter int unsigned TABLE_DEPTH = nte_pkg::TABLE_DEPTH_DEFAULT,
   parameter int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                   clock,
   input  nte_pkg::chain_ctl_type ctl,
   input  logic [COUNT_W-1:0]     wpos,
   input  nte_pkg::entry_type     wdata,
   output nte_pkg::entry_type     head
);

   nte_pkg::entry_type cell_q [TABLE_DEPTH];

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      localparam logic [COUNT_W-1:0] K = COUNT_W'(k);
      nte_pkg::cell_ctl_type cell_ctl;
      nte_pkg::entry_type    next_data;

      // The last cell never shifts; it feeds back on itself
      if (k == TABLE_DEPTH - 1) begin : g_last
         assign next_data = cell_q[k];
      end else begin : g_mid
         assign next_data = cell_q[k+1];
      end

      // Position decode against the broadcast write position
      assign cell_ctl.load_wdata = ctl.wen && (K == wpos);
      assign cell_ctl.load_next  = ctl.shift && (K < wpos);

      nte_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .next_i  (next_data),
         .wdata_i (wdata),
         .data_o  (cell_q[k])
      );
   end

   assign head = cell_q[0];

endmodule

>>> rtl/core/nte_checker.sv
// Port-level checks for the neighbor table, bound to the top level.
module nte_checker #(
   parameter int unsigned TABLE_DEPTH = nte_pkg::TABLE_DEPTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nte_pkg::rsp_type rsp_payload
);

   localparam logic [5:0] DEPTH_C = 6'(TABLE_DEPTH);
   localparam logic       NARROW  = (TABLE_DEPTH < 32);

   // A stalled result keeps its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   // Reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && NARROW |-> {1'b0, rsp_payload.neighbor_count} <= DEPTH_C)
      else $error("neighbor count above table depth");

   // Only a sweep removes entries
   a_removed_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != nte_pkg::STATUS_SWEEP_DONE)
      |-> rsp_payload.removed_count == 5'd0)
      else $error("observe result reports removals");

   // Status stays within its codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= nte_pkg::STATUS_SWEEP_DONE)
      else $error("status code out of range");

endmodule

bind neighbor_table_with_expiry nte_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_nte_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
